>>> rtl/srcc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helpers of the spare remap coverage checker
package srcc_pkg;

  // table depths
  localparam int MAX_LINE_MAPS   = 64;
  localparam int MAX_BUFFER_MAPS = 64;

  localparam int LINE_IDX_W = (MAX_LINE_MAPS > 1) ? $clog2(MAX_LINE_MAPS) : 1;
  localparam int BUF_IDX_W  = (MAX_BUFFER_MAPS > 1) ? $clog2(MAX_BUFFER_MAPS) : 1;
  localparam int ADDR_W     = (LINE_IDX_W > BUF_IDX_W) ? LINE_IDX_W : BUF_IDX_W;
  localparam int LINE_CNT_W = $clog2(MAX_LINE_MAPS + 1);
  localparam int BUF_CNT_W  = $clog2(MAX_BUFFER_MAPS + 1);
  localparam int CNT_W      = (LINE_CNT_W > BUF_CNT_W) ? LINE_CNT_W : BUF_CNT_W;

  // item field widths
  localparam int KIND_W = 3;
  localparam int DOM_W  = 20;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 10;
  localparam int DEST_W = 8;
  localparam int LAT_W  = 16;
  localparam int LINE_W = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int B_W    = (COL_W > DEST_W) ? COL_W : DEST_W;

  // configuration port
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_ROWS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_COLUMNS = 1'd1;

  // input beat layout, domain is stack, channel, bank, group, subarray from bit 0
  localparam int I_DOM_LO    = 0;
  localparam int I_ROW_LO    = I_DOM_LO + DOM_W;
  localparam int I_COL_LO    = I_ROW_LO + ROW_W;
  localparam int I_DEST_LO   = I_COL_LO + COL_W;
  localparam int I_LAT_LO    = I_DEST_LO + DEST_W;
  localparam int IN_FIELDS_W = I_LAT_LO + LAT_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // output beat layout
  localparam int FLAGS_W     = 7;
  localparam int CNT_OUT_W   = 7;
  localparam int O_COVERED   = 0;
  localparam int O_FLAGS_LO  = 1;
  localparam int O_VALID     = O_FLAGS_LO + FLAGS_W;
  localparam int O_ROWS_LO   = O_VALID + 1;
  localparam int O_COLS_LO   = O_ROWS_LO + CNT_OUT_W;
  localparam int OUT_FIELDS_W = O_COLS_LO + CNT_OUT_W;
  localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ROW_MAP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COL_MAP  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BUF_MAP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FAULT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REPORT   = 3'd5;

  // line kinds held in the tables
  localparam logic LK_ROW = 1'b0;
  localparam logic LK_COL = 1'b1;

  // issue flag bits
  localparam int F_NEG_LAT      = 0;
  localparam int F_SRC_CONFLICT = 1;
  localparam int F_SHARED_DEST  = 2;
  localparam int F_ROWS_OVER    = 3;
  localparam int F_COLS_OVER    = 4;
  localparam int F_UNCOVERED    = 5;
  localparam int F_FULL         = 6;

  // one table entry: line maps keep line in a and destination in b,
  // buffer maps keep row in a and column in b
  typedef struct packed {
    logic              kind;
    logic [DOM_W-1:0]  dom;
    logic [LINE_W-1:0] a;
    logic [B_W-1:0]    b;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic kind_eq;
    logic dom_eq;
    logic a_eq;
    logic b_eq;
    logic alt_eq;
  } cmp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              we_src;
    logic              we_dst;
    logic              we_buf;
  } ram_req_t;

  function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [31:0] v);
    logic [31:0] lim;
    lim = 32'((1 << CNT_OUT_W) - 1);
    return (v > lim) ? lim[CNT_OUT_W-1:0] : v[CNT_OUT_W-1:0];
  endfunction

endpackage

>>> rtl/srcc_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module srcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/srcc_cmp.sv
`timescale 1ns / 1ps
// shared entry comparator used by every table scan
module srcc_cmp (
  input  srcc_pkg::entry_t                ent,
  input  srcc_pkg::entry_t                key,
  input  logic [srcc_pkg::LINE_W-1:0]     alt,
  output srcc_pkg::cmp_t                  res
);

  assign res.kind_eq = (ent.kind == key.kind);
  assign res.dom_eq  = (ent.dom == key.dom);
  assign res.a_eq    = (ent.a == key.a);
  assign res.b_eq    = (ent.b == key.b);
  assign res.alt_eq  = (ent.a == alt);

endmodule

>>> rtl/srcc_seq.sv
`timescale 1ns / 1ps
// sequencer: table scans, fill counts, issue flags and the result register
module srcc_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [srcc_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [srcc_pkg::KIND_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [srcc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic [srcc_pkg::CFG_W-1:0]         row_spares,
  input  logic [srcc_pkg::CFG_W-1:0]         col_spares,
  output srcc_pkg::ram_req_t                 ram,
  input  srcc_pkg::entry_t                   src_rdata,
  input  srcc_pkg::entry_t                   dst_rdata,
  input  srcc_pkg::entry_t                   buf_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC,
    ST_DST,
    ST_BUF,
    ST_FSRC,
    ST_FINISH
  } state_t;

  state_t state;

  // item held for the whole scan
  logic [srcc_pkg::KIND_W-1:0] kind_q;
  logic [srcc_pkg::DOM_W-1:0]  dom_q;
  logic [srcc_pkg::ROW_W-1:0]  row_q;
  logic [srcc_pkg::COL_W-1:0]  col_q;
  logic [srcc_pkg::DEST_W-1:0] dest_q;

  logic [srcc_pkg::LINE_CNT_W-1:0] src_used;
  logic [srcc_pkg::LINE_CNT_W-1:0] dst_used;
  logic [srcc_pkg::BUF_CNT_W-1:0]  buf_used;
  logic [srcc_pkg::LINE_CNT_W-1:0] row_count;
  logic [srcc_pkg::LINE_CNT_W-1:0] column_count;
  logic                            valid_flag;
  logic [srcc_pkg::FLAGS_W-1:0]    flags;
  logic                            covered;

  // scan pointer and the read in flight
  logic [srcc_pkg::CNT_W-1:0]  ra;
  logic [srcc_pkg::CNT_W-1:0]  ra_next;
  logic                        pend;
  logic                        pend_next;
  logic [srcc_pkg::ADDR_W-1:0] pidx;

  srcc_pkg::entry_t               key;
  srcc_pkg::entry_t               ent;
  logic [srcc_pkg::LINE_W-1:0]    alt;
  srcc_pkg::cmp_t                 res;
  logic [srcc_pkg::CNT_W-1:0]     used_sel;
  logic                           match;
  logic                           issue;
  logic                           hit;
  logic                           miss;
  logic                           scanning;
  logic                           out_load;
  logic                           src_room;
  logic                           dst_room;
  logic                           buf_room;
  logic                           is_line;
  logic                           neg;
  logic [srcc_pkg::FLAGS_W-1:0]   start_flags;
  logic [srcc_pkg::OUT_DATA_W-1:0] out_word;
  logic [srcc_pkg::KIND_W-1:0]    in_kind;

  srcc_cmp u_cmp (
    .ent (ent),
    .key (key),
    .alt (alt),
    .res (res)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_kind  = s_tuser;
  assign is_line  = (kind_q == srcc_pkg::KIND_ROW_MAP) || (kind_q == srcc_pkg::KIND_COL_MAP);
  assign neg      = s_tdata[srcc_pkg::I_LAT_LO + srcc_pkg::LAT_W - 1];

  assign src_room = src_used < srcc_pkg::LINE_CNT_W'(srcc_pkg::MAX_LINE_MAPS);
  assign dst_room = dst_used < srcc_pkg::LINE_CNT_W'(srcc_pkg::MAX_LINE_MAPS);
  assign buf_room = buf_used < srcc_pkg::BUF_CNT_W'(srcc_pkg::MAX_BUFFER_MAPS);

  assign scanning = (state == ST_SRC) || (state == ST_DST) || (state == ST_BUF) ||
                    (state == ST_FSRC);
  assign out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    key.kind = (kind_q == srcc_pkg::KIND_COL_MAP) ? srcc_pkg::LK_COL : srcc_pkg::LK_ROW;
    key.dom  = dom_q;
    key.a    = (kind_q == srcc_pkg::KIND_COL_MAP) ? srcc_pkg::LINE_W'(col_q)
                                                  : srcc_pkg::LINE_W'(row_q);
    key.b    = is_line ? srcc_pkg::B_W'(dest_q) : srcc_pkg::B_W'(col_q);
    alt      = srcc_pkg::LINE_W'(col_q);
  end

  // flags known at accept time
  always_comb begin
    start_flags = '0;
    case (in_kind)
      srcc_pkg::KIND_ROW_MAP, srcc_pkg::KIND_COL_MAP, srcc_pkg::KIND_BUF_MAP: begin
        start_flags[srcc_pkg::F_NEG_LAT] = neg;
      end
      srcc_pkg::KIND_REPORT: begin
        start_flags[srcc_pkg::F_ROWS_OVER] = 32'(row_count) > 32'(row_spares);
        start_flags[srcc_pkg::F_COLS_OVER] = 32'(column_count) > 32'(col_spares);
      end
      default: begin
      end
    endcase
  end

  // pick the table under scan and its match rule
  always_comb begin
    case (state)
      ST_SRC: begin
        ent      = src_rdata;
        used_sel = srcc_pkg::CNT_W'(src_used);
        match    = res.kind_eq & res.dom_eq & res.a_eq;
      end
      ST_DST: begin
        ent      = dst_rdata;
        used_sel = srcc_pkg::CNT_W'(dst_used);
        match    = res.kind_eq & res.dom_eq & res.b_eq;
      end
      ST_BUF: begin
        ent      = buf_rdata;
        used_sel = srcc_pkg::CNT_W'(buf_used);
        match    = res.dom_eq & res.a_eq & res.b_eq;
      end
      ST_FSRC: begin
        ent      = src_rdata;
        used_sel = srcc_pkg::CNT_W'(src_used);
        // row lines match the fault row, column lines the fault column
        match    = res.dom_eq & ((src_rdata.kind == srcc_pkg::LK_ROW) ? res.a_eq : res.alt_eq);
      end
      default: begin
        ent      = src_rdata;
        used_sel = '0;
        match    = 1'b0;
      end
    endcase
  end

  assign issue = ra < used_sel;
  assign hit   = pend & match;
  assign miss  = ~hit & ~issue;

  // scan pointer restarts whenever a scan ends and outside the scans
  always_comb begin
    ra_next   = ra;
    pend_next = pend;
    if (scanning) begin
      if (issue) begin
        ra_next = ra + srcc_pkg::CNT_W'(1);
      end
      pend_next = issue;
    end
    if (hit || miss) begin
      ra_next   = '0;
      pend_next = 1'b0;
    end
  end

  always_comb begin
    ram.rd_addr = ra[srcc_pkg::ADDR_W-1:0];
    ram.wr_data = key;
    case (state)
      ST_DST:  ram.wr_addr = hit ? pidx : srcc_pkg::ADDR_W'(dst_used);
      ST_BUF:  ram.wr_addr = srcc_pkg::ADDR_W'(buf_used);
      default: ram.wr_addr = hit ? pidx : srcc_pkg::ADDR_W'(src_used);
    endcase
    ram.we_src = (state == ST_SRC) && (hit || (miss && src_room));
    ram.we_dst = (state == ST_DST) && (hit || (miss && dst_room));
    ram.we_buf = (state == ST_BUF) && (kind_q == srcc_pkg::KIND_BUF_MAP) && miss && buf_room;
  end

  always_comb begin
    out_word = '0;
    out_word[srcc_pkg::O_COVERED] = covered;
    out_word[srcc_pkg::O_FLAGS_LO +: srcc_pkg::FLAGS_W] = flags;
    out_word[srcc_pkg::O_VALID] = valid_flag & ~|flags;
    out_word[srcc_pkg::O_ROWS_LO +: srcc_pkg::CNT_OUT_W] = srcc_pkg::sat_count(32'(row_count));
    out_word[srcc_pkg::O_COLS_LO +: srcc_pkg::CNT_OUT_W] =
      srcc_pkg::sat_count(32'(column_count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      src_used     <= '0;
      dst_used     <= '0;
      buf_used     <= '0;
      row_count    <= '0;
      column_count <= '0;
      valid_flag   <= 1'b1;
      m_tvalid     <= 1'b0;
      ra           <= '0;
      pend         <= 1'b0;
    end else begin
      ra   <= ra_next;
      pend <= pend_next;
      if (scanning && issue) begin
        pidx <= ra[srcc_pkg::ADDR_W-1:0];
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= out_word;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind_q  <= in_kind;
            dom_q   <= s_tdata[srcc_pkg::I_DOM_LO +: srcc_pkg::DOM_W];
            row_q   <= s_tdata[srcc_pkg::I_ROW_LO +: srcc_pkg::ROW_W];
            col_q   <= s_tdata[srcc_pkg::I_COL_LO +: srcc_pkg::COL_W];
            dest_q  <= s_tdata[srcc_pkg::I_DEST_LO +: srcc_pkg::DEST_W];
            covered <= 1'b0;
            flags   <= start_flags;
            case (in_kind)
              srcc_pkg::KIND_CLEAR: begin
                src_used     <= '0;
                dst_used     <= '0;
                buf_used     <= '0;
                row_count    <= '0;
                column_count <= '0;
                valid_flag   <= 1'b1;
                state        <= ST_FINISH;
              end
              srcc_pkg::KIND_ROW_MAP, srcc_pkg::KIND_COL_MAP: begin
                state <= ST_SRC;
              end
              srcc_pkg::KIND_BUF_MAP: begin
                state <= ST_BUF;
              end
              srcc_pkg::KIND_FAULT: begin
                state <= ST_BUF;
              end
              srcc_pkg::KIND_REPORT: begin
                state <= ST_FINISH;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SRC: begin
          if (hit) begin
            if (!res.b_eq) begin
              flags[srcc_pkg::F_SRC_CONFLICT] <= 1'b1;
            end
            state <= ST_DST;
          end else if (miss) begin
            if (src_room) begin
              src_used <= src_used + srcc_pkg::LINE_CNT_W'(1);
              if (key.kind == srcc_pkg::LK_ROW) begin
                row_count <= row_count + srcc_pkg::LINE_CNT_W'(1);
              end else begin
                column_count <= column_count + srcc_pkg::LINE_CNT_W'(1);
              end
            end else begin
              flags[srcc_pkg::F_FULL] <= 1'b1;
            end
            state <= ST_DST;
          end
        end
        ST_DST: begin
          if (hit) begin
            if (!res.a_eq) begin
              flags[srcc_pkg::F_SHARED_DEST] <= 1'b1;
            end
            state <= ST_FINISH;
          end else if (miss) begin
            if (dst_room) begin
              dst_used <= dst_used + srcc_pkg::LINE_CNT_W'(1);
            end else begin
              flags[srcc_pkg::F_FULL] <= 1'b1;
            end
            state <= ST_FINISH;
          end
        end
        ST_BUF: begin
          if (hit) begin
            if (kind_q == srcc_pkg::KIND_FAULT) begin
              covered <= 1'b1;
            end
            state <= ST_FINISH;
          end else if (miss) begin
            if (kind_q == srcc_pkg::KIND_FAULT) begin
              state <= ST_FSRC;
            end else begin
              if (buf_room) begin
                buf_used <= buf_used + srcc_pkg::BUF_CNT_W'(1);
              end else begin
                flags[srcc_pkg::F_FULL] <= 1'b1;
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_FSRC: begin
          if (hit) begin
            covered <= 1'b1;
            state   <= ST_FINISH;
          end else if (miss) begin
            flags[srcc_pkg::F_UNCOVERED] <= 1'b1;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait for the result register to drain
          if (out_load) begin
            valid_flag <= valid_flag & ~|flags;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/spare_remap_coverage_checker_core.sv
`timescale 1ns / 1ps
// top level: configuration registers, the three tables and the sequencer
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  s_*      | in        | s_tvalid / s_tready  | s_tuser kind, s_tdata item fields
//  m_*      | out       | m_tvalid / m_tready  | m_tdata result fields
//  cfg_*    | in        | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// from the accepting edge to the edge that raises m_tvalid: clear, report and unused
// kinds go straight to the finish state, a buffer map scans the buffer table, a row
// or column map scans the source and then the destination table, a fault check scans
// the buffer table and, on a miss there, the source table; s_tready returns on that edge.
// rst is synchronous and empties the tables through their fill counts, no sweep.
// a result waits in the output register while the next item is accepted; a
// finished item holds in place only if that register is still full.
module spare_remap_coverage_checker_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // stack_id, channel, bank, subarray_group, subarray, row, column,
  // destination, latency, zero pad
  input  logic [srcc_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind
  input  logic [srcc_pkg::KIND_W-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // covered, issue_flags, section_valid, row_source_count,
  // column_source_count, zero pad
  output logic [srcc_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srcc_pkg::CFG_W-1:0]        cfg_data
);

  logic [srcc_pkg::CFG_W-1:0] row_spares;
  logic [srcc_pkg::CFG_W-1:0] col_spares;

  srcc_pkg::ram_req_t ram;
  srcc_pkg::entry_t   src_rdata;
  srcc_pkg::entry_t   dst_rdata;
  srcc_pkg::entry_t   buf_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_spares <= '0;
      col_spares <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        srcc_pkg::REG_SPARE_ROWS:    row_spares <= cfg_data;
        srcc_pkg::REG_SPARE_COLUMNS: col_spares <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  srcc_ram #(
    .WIDTH (srcc_pkg::ENTRY_W),
    .DEPTH (srcc_pkg::MAX_LINE_MAPS)
  ) u_src_ram (
    .clk   (clk),
    .we    (ram.we_src),
    .waddr (ram.wr_addr[srcc_pkg::LINE_IDX_W-1:0]),
    .wdata (ram.wr_data),
    .raddr (ram.rd_addr[srcc_pkg::LINE_IDX_W-1:0]),
    .rdata (src_rdata)
  );

  srcc_ram #(
    .WIDTH (srcc_pkg::ENTRY_W),
    .DEPTH (srcc_pkg::MAX_LINE_MAPS)
  ) u_dst_ram (
    .clk   (clk),
    .we    (ram.we_dst),
    .waddr (ram.wr_addr[srcc_pkg::LINE_IDX_W-1:0]),
    .wdata (ram.wr_data),
    .raddr (ram.rd_addr[srcc_pkg::LINE_IDX_W-1:0]),
    .rdata (dst_rdata)
  );

  srcc_ram #(
    .WIDTH (srcc_pkg::ENTRY_W),
    .DEPTH (srcc_pkg::MAX_BUFFER_MAPS)
  ) u_buf_ram (
    .clk   (clk),
    .we    (ram.we_buf),
    .waddr (ram.wr_addr[srcc_pkg::BUF_IDX_W-1:0]),
    .wdata (ram.wr_data),
    .raddr (ram.rd_addr[srcc_pkg::BUF_IDX_W-1:0]),
    .rdata (buf_rdata)
  );

  srcc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .row_spares (row_spares),
    .col_spares (col_spares),
    .ram        (ram),
    .src_rdata  (src_rdata),
    .dst_rdata  (dst_rdata),
    .buf_rdata  (buf_rdata)
  );

endmodule

>>> rtl/srcc_checker.sv
`timescale 1ns / 1ps
// port level checks of the spare remap coverage checker
module srcc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [srcc_pkg::OUT_DATA_W-1:0]   m_tdata
);

  // no result may be presented straight after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // one item at a time: input side closes after every accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after accepting a beat");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

  // a clean section carries no issue in the same beat
  a_valid_no_issue: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[srcc_pkg::O_VALID]) |->
      (m_tdata[srcc_pkg::O_FLAGS_LO +: srcc_pkg::FLAGS_W] == '0))
    else $error("section valid with issue flags set");

  // a fault cannot be both covered and uncovered
  a_cover_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[srcc_pkg::O_COVERED] &&
                   m_tdata[srcc_pkg::O_FLAGS_LO + srcc_pkg::F_UNCOVERED]))
    else $error("fault reported covered and uncovered");

endmodule

bind spare_remap_coverage_checker_core srcc_checker u_srcc_checker (.*);
